FILE: rtl/core/acms_pkg.sv
// Shared constants for the ADC current meter statistics block.
package acms_pkg;

  localparam int TABLE_POINTS = 16;
  localparam int TAB_IDX_W    = $clog2(TABLE_POINTS);
  localparam int PC_W         = 5;

  // Request kinds carried on tuser
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Reciprocal of 32767 in Q.46, exact for dividends below 2^31
  localparam logic [31:0] SC_RECIP = 32'd2147549187;

  // Shared divider: unsigned magnitudes, one quotient bit per cycle
  localparam int DIV_N_W   = 48;
  localparam int DIV_D_W   = 32;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  typedef enum logic [2:0] {
    CFG_CAL_ENABLE   = 3'd0,
    CFG_CAL_ZERO_IN  = 3'd1,
    CFG_CAL_ZERO_OUT = 3'd2,
    CFG_CAL_SLOPE    = 3'd3,
    CFG_POINT_COUNT  = 3'd4,
    CFG_HOUR_SCALE   = 3'd5
  } cfg_idx_e;

endpackage

FILE: rtl/core/acms_div.sv
// Radix-2 restoring divider on unsigned magnitudes, one quotient bit per cycle.
module acms_div
  import acms_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DIV_N_W-1:0] dividend_i,
  input  logic [DIV_D_W-1:0] divisor_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [DIV_N_W-1:0] quotient_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_D_W-1:0]   rem_q;
  logic [DIV_D_W-1:0]   dsr_q;
  logic [DIV_N_W-1:0]   quo_q;
  logic [DIV_D_W:0]     rem_sh;
  logic                 ge;

  assign rem_sh = {rem_q, quo_q[DIV_N_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        dsr_q  <= divisor_i;
        quo_q  <= dividend_i;
      end else if (busy_q) begin
        rem_q <= ge ? DIV_D_W'(rem_sh - {1'b0, dsr_q}) : rem_sh[DIV_D_W-1:0];
        quo_q <= {quo_q[DIV_N_W-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_N_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: rtl/core/adc_current_meter_stats.sv
// ADC current meter: scaling, calibration, table interpolation and running statistics.
//
// Input stream: s_axis_tuser_i is the command (0 loads a table point, 1 processes a
// sample). A load is taken while idle and gives no result. A sample request gives
// one result on the output stream with the sample's current and voltage, the raw
// statistics and the accumulated charge.
// Per sample the sequencer converts the raw code and then the running average, each
// conversion being a multiply, a reciprocal multiply for the division by 32767, an
// optional calibration multiply, a table walk over up to point_count points and an
// interpolation division. The average division lies between the two conversions and
// three charge multiplies follow them; the three passes through the one-bit-per-cycle
// divider take most of the time. Calibration off skips the calibration multiply, a
// flat segment skips a division. s_axis_tready_o is low from acceptance until the
// sequencer is back in idle.
// The result sits in an output register; the next request is accepted while it waits.
// If the receiver still holds off when the following result is done, the sequencer
// waits in its output state until the register frees.
// Reset clears the statistics (minimum to 32767), the config registers to their
// defaults and the output valid. Table points are undefined until loaded.
// Config writes (cfg_we_i) take effect at once and are meant for idle periods only.
module adc_current_meter_stats
  import acms_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // tdata: point_index[3:0], point_volts[23:4], point_ma[47:24], raw_sample[63:48]
  input  logic [63:0]  s_axis_tdata_i,
  // tuser: command
  input  logic         s_axis_tuser_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tdata: current_ma[23:0], voltage[43:24], last_sample[59:44], min_sample[75:60],
  //        max_sample[91:76], average_sample[107:92], total_charge[155:108],
  //        samples_seen[187:156], zero pad[191:188]
  output logic [191:0] m_axis_tdata_o,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_addr_i,
  input  logic [31:0]  cfg_wdata_i
);

  typedef enum logic [4:0] {
    S_IDLE, S_SC_MUL, S_SC_RCP, S_SC_QUO, S_CAL_MUL, S_CAL_ADD, S_SRCH,
    S_INT_MUL, S_IN_DIV, S_IN_WAIT, S_CONV_END, S_AV_DIV, S_AV_WAIT,
    S_CH_MUL1, S_CH_MUL2, S_CH_MUL3, S_CH_SUM, S_OUT
  } state_e;

  function automatic logic signed [19:0] sat20(input logic signed [49:0] v);
    if (v > 50'sd524287)       return 20'sh7ffff;
    else if (v < -50'sd524288) return 20'sh80000;
    else                       return v[19:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [49:0] v);
    if (v > 50'sd8388607)       return 24'sh7fffff;
    else if (v < -50'sd8388608) return 24'sh800000;
    else                        return v[23:0];
  endfunction

  state_e state_q;

  // config registers
  logic               cal_en_q;
  logic signed [19:0] zin_q, zout_q, slope_q;
  logic [PC_W-1:0]    pc_q;
  logic [31:0]        hs_q;

  // statistics
  logic signed [15:0] last_q, min_q, max_q;
  logic signed [47:0] sum_q;
  logic [31:0]        total_q;

  // table
  logic signed [19:0] tab_v_q [TABLE_POINTS];
  logic signed [23:0] tab_m_q [TABLE_POINTS];

  // working registers
  logic               phase_q;   // 0: raw sample, 1: average
  logic signed [15:0] src_q;
  logic signed [19:0] x_q;
  logic signed [19:0] x0_q, x1_q;
  logic signed [23:0] y0_q, y1_q;
  logic [TAB_IDX_W-1:0] k_q;
  logic signed [23:0] cur_q;
  logic signed [19:0] v_raw_q;
  logic signed [23:0] cur_raw_q;
  logic signed [15:0] avg_q;
  logic [31:0]        p_q;
  logic [55:0]        acc_q;
  logic signed [47:0] chg_q;
  logic               div_neg_q;
  logic signed [65:0] prod_q;
  logic               m_valid_q;
  logic [191:0]       m_data_q;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;

  // divider
  logic               div_start, div_busy, div_done;
  logic [DIV_N_W-1:0] div_dvd, div_quo;
  logic [DIV_D_W-1:0] div_dsr;
  logic               div_neg_d;
  logic signed [48:0] quo_s;

  logic [PC_W-1:0]    n_pts;
  logic signed [20:0] cal_d, dv, den;
  logic signed [24:0] dy;
  logic [23:0]        mag;
  logic [65:0]        prod_abs;
  logic [47:0]        sum_abs;
  logic [56:0]        q_chg;
  logic [16:0]        sc_quo;
  logic signed [19:0] tv;
  logic signed [23:0] tm;
  logic               in_acc;
  logic signed [15:0] raw_in;

  assign n_pts = (pc_q < PC_W'(2)) ? PC_W'(2) :
                 (pc_q > PC_W'(TABLE_POINTS)) ? PC_W'(TABLE_POINTS) : pc_q;

  assign cal_d    = 21'(x_q) - 21'(zin_q);
  assign dv       = 21'(x_q) - 21'(x1_q);
  assign den      = 21'(x1_q) - 21'(x0_q);
  assign dy       = 25'(y1_q) - 25'(y0_q);
  assign mag      = cur_q[23] ? 24'(-cur_q) : 24'(cur_q);
  assign prod_abs = prod_q[65] ? 66'(-prod_q) : 66'(prod_q);
  assign sum_abs  = sum_q[47] ? 48'(-sum_q) : 48'(sum_q);
  assign q_chg    = 57'(acc_q) + 57'(prod_q[55:32]);
  assign sc_quo   = prod_q[62:46];   // |raw*40960| / 32767
  assign quo_s    = div_neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  assign tv       = tab_v_q[k_q];
  assign tm       = tab_m_q[k_q];
  assign raw_in   = s_axis_tdata_i[63:48];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SC_MUL: begin
        mul_a = 33'(src_q);
        mul_b = 33'sd40960;
      end
      S_SC_RCP: begin
        mul_a = $signed({2'b0, prod_abs[30:0]});
        mul_b = $signed({1'b0, SC_RECIP});
      end
      S_CAL_MUL: begin
        mul_a = 33'(slope_q);
        mul_b = 33'(cal_d);
      end
      S_INT_MUL: begin
        mul_a = 33'(dy);
        mul_b = 33'(dv);
      end
      S_CH_MUL1: begin
        mul_a = $signed({1'b0, total_q});
        mul_b = $signed({1'b0, hs_q});
      end
      S_CH_MUL2: begin
        mul_a = $signed({9'b0, mag});
        mul_b = $signed({1'b0, prod_q[63:32]});
      end
      S_CH_MUL3: begin
        mul_a = $signed({9'b0, mag});
        mul_b = $signed({1'b0, p_q});
      end
      default: ;
    endcase
  end

  // divider launch: operands and sign of the true quotient
  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dsr   = '0;
    div_neg_d = div_neg_q;
    case (state_q)
      S_SC_RCP: begin
        // sign of the scaled sample; the magnitude goes through the reciprocal
        div_neg_d = prod_q[65];
      end
      S_IN_DIV: begin
        div_start = 1'b1;
        div_dvd   = prod_abs[DIV_N_W-1:0];
        div_dsr   = DIV_D_W'(den[20] ? 21'(-den) : den);
        div_neg_d = prod_q[65] ^ den[20];
      end
      S_AV_DIV: begin
        div_start = 1'b1;
        div_dvd   = sum_abs;
        div_dsr   = total_q;
        div_neg_d = sum_q[47];
      end
      default: ;
    endcase
  end

  acms_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // table: written by load requests, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tuser_i == CMD_LOAD) begin
      tab_v_q[s_axis_tdata_i[TAB_IDX_W-1:0]] <= s_axis_tdata_i[23:4];
      tab_m_q[s_axis_tdata_i[TAB_IDX_W-1:0]] <= s_axis_tdata_i[47:24];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cal_en_q  <= 1'b0;
      zin_q     <= '0;
      zout_q    <= '0;
      slope_q   <= 20'sd65536;
      pc_q      <= PC_W'(2);
      hs_q      <= 32'd1272584;
      last_q    <= '0;
      min_q     <= 16'sd32767;
      max_q     <= '0;
      sum_q     <= '0;
      total_q   <= '0;
      phase_q   <= 1'b0;
      src_q     <= '0;
      x_q       <= '0;
      x0_q      <= '0;
      x1_q      <= '0;
      y0_q      <= '0;
      y1_q      <= '0;
      k_q       <= '0;
      cur_q     <= '0;
      v_raw_q   <= '0;
      cur_raw_q <= '0;
      avg_q     <= '0;
      p_q       <= '0;
      acc_q     <= '0;
      chg_q     <= '0;
      div_neg_q <= 1'b0;
      prod_q    <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      prod_q    <= mul_a * mul_b;
      div_neg_q <= div_neg_d;

      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_CAL_ENABLE:   cal_en_q <= cfg_wdata_i[0];
          CFG_CAL_ZERO_IN:  zin_q    <= cfg_wdata_i[19:0];
          CFG_CAL_ZERO_OUT: zout_q   <= cfg_wdata_i[19:0];
          CFG_CAL_SLOPE:    slope_q  <= cfg_wdata_i[19:0];
          CFG_POINT_COUNT:  pc_q     <= cfg_wdata_i[PC_W-1:0];
          CFG_HOUR_SCALE:   hs_q     <= cfg_wdata_i;
          default: ;
        endcase
      end

      // the output state refills the register itself
      if (m_valid_q && m_axis_tready_i && state_q != S_OUT) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc && s_axis_tuser_i != CMD_LOAD) begin
            // statistics move at once; the conversions below do not read them
            last_q <= raw_in;
            if (raw_in < min_q) min_q <= raw_in;
            if (raw_in > max_q) max_q <= raw_in;
            if (total_q != '1) begin
              sum_q   <= sum_q + 48'(raw_in);
              total_q <= total_q + 32'd1;
            end
            src_q   <= raw_in;
            phase_q <= 1'b0;
            state_q <= S_SC_MUL;
          end
        end
        S_SC_MUL: state_q <= S_SC_RCP;
        S_SC_RCP: state_q <= S_SC_QUO;
        S_SC_QUO: begin
          x_q     <= div_neg_q ? -$signed({3'b0, sc_quo}) : $signed({3'b0, sc_quo});
          k_q     <= '0;
          state_q <= cal_en_q ? S_CAL_MUL : S_SRCH;
        end
        S_CAL_MUL: state_q <= S_CAL_ADD;
        S_CAL_ADD: begin
          // arithmetic shift gives the floor of the Q.16 product
          x_q     <= sat20(50'(zout_q) + 50'(prod_q >>> 16));
          state_q <= S_SRCH;
        end
        S_SRCH: begin
          x0_q <= x1_q;
          y0_q <= y1_q;
          x1_q <= tv;
          y1_q <= tm;
          if (k_q != '0 && !((PC_W'(k_q) < n_pts - PC_W'(1)) && (tv <= x_q))) begin
            state_q <= S_INT_MUL;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        S_INT_MUL: begin
          if (den == '0) begin
            // flat segment: current is the upper point
            cur_q   <= y1_q;
            state_q <= S_CONV_END;
          end else begin
            state_q <= S_IN_DIV;
          end
        end
        S_IN_DIV: state_q <= S_IN_WAIT;
        S_IN_WAIT: begin
          if (div_done) begin
            cur_q   <= sat24(50'(y1_q) + 50'(quo_s));
            state_q <= S_CONV_END;
          end
        end
        S_CONV_END: begin
          if (!phase_q) begin
            v_raw_q   <= x_q;
            cur_raw_q <= cur_q;
            state_q   <= S_AV_DIV;
          end else begin
            state_q <= S_CH_MUL1;
          end
        end
        S_AV_DIV: state_q <= S_AV_WAIT;
        S_AV_WAIT: begin
          if (div_done) begin
            avg_q   <= quo_s[15:0];
            src_q   <= quo_s[15:0];
            phase_q <= 1'b1;
            state_q <= S_SC_MUL;
          end
        end
        S_CH_MUL1: state_q <= S_CH_MUL2;
        S_CH_MUL2: begin
          p_q     <= prod_q[31:0];
          state_q <= S_CH_MUL3;
        end
        S_CH_MUL3: begin
          acc_q   <= prod_q[55:0];
          state_q <= S_CH_SUM;
        end
        S_CH_SUM: begin
          if (cur_q[23]) begin
            chg_q <= (q_chg > 57'h800000000000) ? 48'sh800000000000
                                                : 48'(-$signed({1'b0, q_chg}));
          end else begin
            chg_q <= (q_chg > 57'h7fffffffffff) ? 48'sh7fffffffffff : q_chg[47:0];
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_data_q  <= {4'b0, total_q, chg_q, avg_q, max_q, min_q, last_q,
                          v_raw_q, cur_raw_q};
            m_valid_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tvalid_o = m_valid_q;

  a_count_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q >= $past(total_q))
    else $error("sample count went backwards");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q != '0) |-> (min_q <= max_q))
    else $error("minimum above maximum after samples");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider launched while busy");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH) |-> (PC_W'(k_q) < n_pts))
    else $error("table walk beyond point count");

endmodule

FILE: tb/sv/tb.sv
// Testbench for the ADC current meter: directed and random requests checked against a local model.
`timescale 1ns / 1ps

module tb;
  import acms_pkg::*;

  // Output field bundle, one per processed sample
  typedef struct packed {
    logic [23:0] current_ma;
    logic [19:0] voltage;
    logic [15:0] last_sample;
    logic [15:0] min_sample;
    logic [15:0] max_sample;
    logic [15:0] average_sample;
    logic [47:0] total_charge;
    logic [31:0] samples_seen;
  } meter_res_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic [63:0]  s_axis_tdata_i = '0;
  logic         s_axis_tuser_i = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [191:0] m_axis_tdata_o;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_addr_i = '0;
  logic [31:0]  cfg_wdata_i = '0;

  adc_current_meter_stats DUT (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Model state: config copy, table shadow and statistics
  logic        m_cal_en;
  logic signed [19:0] m_zero_in, m_zero_out, m_slope;
  logic [4:0]  m_npts;
  logic [31:0] m_hour;
  logic signed [63:0] m_tv [TABLE_POINTS];
  logic signed [63:0] m_tma [TABLE_POINTS];
  logic signed [63:0] m_last, m_min, m_max, m_sum;
  logic [63:0] m_count;

  meter_res_t expected_q[$];
  int unsigned n_errors = 0;
  bit          rx_idle_en = 1'b1;  // receiver random stalls
  bit          tx_idle_en = 1'b1;  // sender random gaps
  int          hold_cycles = 0;    // long receiver hold-off

  function automatic logic signed [63:0] sat(logic signed [63:0] v, int w);
    logic signed [63:0] hi, lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : (v < lo) ? lo : v;
  endfunction

  function automatic logic signed [63:0] to_volts(logic signed [63:0] raw);
    logic signed [63:0] x, p;
    x = (raw * 40960) / 32767;
    if (m_cal_en) begin
      p = 64'(m_slope) * (x - 64'(m_zero_in));
      // floor division by 2^16
      x = 64'(m_zero_out) + (p >>> 16);
    end
    return sat(x, 20);
  endfunction

  function automatic logic signed [63:0] to_milliamps(logic signed [63:0] v);
    int n, i1;
    logic signed [63:0] x0, x1, y0, y1, den, r;
    n = m_npts;
    if (n < 2) n = 2;
    if (n > TABLE_POINTS) n = TABLE_POINTS;
    i1 = 1;
    while (i1 < n - 1 && m_tv[i1] <= v) i1++;
    x0 = m_tv[i1-1]; x1 = m_tv[i1]; y0 = m_tma[i1-1]; y1 = m_tma[i1];
    den = x1 - x0;
    r = (den == 0) ? y1 : y1 + ((y1 - y0) * (v - x1)) / den;
    return sat(r, 24);
  endfunction

  function automatic logic signed [63:0] charge_mah(logic signed [63:0] cur, logic [63:0] cnt);
    logic [63:0] mag, p, q, lim;
    mag = (cur < 0) ? -cur : cur;
    p = cnt * 64'(m_hour);
    q = mag * (p >> 32) + ((mag * p[31:0]) >> 32);
    lim = 64'd1 << 47;
    if (cur < 0) return (q > lim) ? -$signed(lim) : -$signed(q);
    return (q > lim - 1) ? $signed(lim - 1) : $signed(q);
  endfunction

  // Apply one accepted request to the model; queue a result for samples
  task automatic predict_request(logic cmd, logic [63:0] d);
    logic signed [63:0] raw, v, avg;
    meter_res_t r;
    if (cmd == CMD_LOAD) begin
      m_tv[d[3:0]]  = 64'($signed(d[23:4]));
      m_tma[d[3:0]] = 64'($signed(d[47:24]));
      return;
    end
    raw = 64'($signed(d[63:48]));
    v = to_volts(raw);
    r.current_ma = 24'(to_milliamps(v));
    r.voltage    = 20'(v);
    m_last = raw;
    if (raw < m_min) m_min = raw;
    if (raw > m_max) m_max = raw;
    if (m_count < 64'hFFFF_FFFF) begin
      m_sum += raw;
      m_count++;
    end
    avg = (m_count == 0) ? 0 : m_sum / $signed(m_count);
    r.last_sample = 16'(m_last);
    r.min_sample = 16'(m_min);
    r.max_sample = 16'(m_max);
    r.average_sample = 16'(avg);
    r.total_charge = 48'(charge_mah(to_milliamps(to_volts(avg)), m_count));
    r.samples_seen = 32'(m_count);
    expected_q = {expected_q, r};
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // Sender: one request, with optional idle burst ahead of it
  task automatic send_request(logic cmd, logic [63:0] d);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= d;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_request(cmd, d);
  endtask

  task automatic go_idle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] pack_load(int idx, logic [19:0] pv, logic [23:0] pm);
    return {16'(0), pm, pv, 4'(idx)};
  endfunction

  task automatic send_sample(logic [15:0] raw);
    send_request(CMD_SAMPLE, {raw, 48'(0)});
  endtask

  // Waits for every result, plus margin for a trailing load
  task automatic drain();
    int guard;
    go_idle();
    guard = 0;
    while (expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
  endtask

  // Input is held off during the write so no request is offered twice
  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    s_axis_tvalid_i <= 1'b0;
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_CAL_ENABLE:   m_cal_en = val[0];
      CFG_CAL_ZERO_IN:  m_zero_in = val[19:0];
      CFG_CAL_ZERO_OUT: m_zero_out = val[19:0];
      CFG_CAL_SLOPE:    m_slope = val[19:0];
      CFG_POINT_COUNT:  m_npts = val[4:0];
      CFG_HOUR_SCALE:   m_hour = val;
      default: ;
    endcase
  endtask

  // Ascending table of 16 evenly spaced voltage points; random currents, or alternating full-scale ones when extreme
  task automatic load_table(bit extreme);
    logic signed [19:0] v;
    int order[16];
    foreach (order[i]) order[i] = i;
    order.shuffle();
    v = extreme ? -20'sd524288 : 20'($signed($urandom_range(0, 60000)) - 30000);
    for (int i = 0; i < 16; i++) begin
      logic signed [63:0] pv;
      pv = -64'sd524288 + i * 64'sd69905;
      if (!extreme) pv = 64'(v) + i * ($urandom_range(0, 3) == 0 ? 0 : 4000);
      if (extreme && i == 15) pv = 524287;
      send_request(CMD_LOAD, pack_load(order[i], 20'(pv),
                   extreme ? (i[0] ? 24'h7FFFFF : 24'h800000) : 24'($urandom)));
    end
    // fix order dependent volts: re-send in index order for monotonicity
    for (int i = 0; i < 16; i++) begin
      logic signed [63:0] pv;
      pv = extreme ? -64'sd524288 + i * 64'sd69905 : 64'(v) + i * 4000;
      if (extreme && i == 15) pv = 524287;
      send_request(CMD_LOAD, pack_load(i, 20'(pv), 24'(m_tma[i])));
    end
  endtask

  // Checker: compares every accepted result with the oldest expectation
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      meter_res_t g, e;
      g.current_ma     = m_axis_tdata_o[23:0];
      g.voltage        = m_axis_tdata_o[43:24];
      g.last_sample    = m_axis_tdata_o[59:44];
      g.min_sample     = m_axis_tdata_o[75:60];
      g.max_sample     = m_axis_tdata_o[91:76];
      g.average_sample = m_axis_tdata_o[107:92];
      g.total_charge   = m_axis_tdata_o[155:108];
      g.samples_seen   = m_axis_tdata_o[187:156];
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata_o[63:0], 0);
      end else begin
        e = expected_q.pop_front();
        if (g.current_ma != e.current_ma) report_mismatch("current_ma", g.current_ma, e.current_ma);
        if (g.voltage != e.voltage) report_mismatch("voltage", g.voltage, e.voltage);
        if (g.last_sample != e.last_sample) report_mismatch("last", g.last_sample, e.last_sample);
        if (g.min_sample != e.min_sample) report_mismatch("min", g.min_sample, e.min_sample);
        if (g.max_sample != e.max_sample) report_mismatch("max", g.max_sample, e.max_sample);
        if (g.average_sample != e.average_sample)
          report_mismatch("average", g.average_sample, e.average_sample);
        if (g.total_charge != e.total_charge)
          report_mismatch("charge", g.total_charge, e.total_charge);
        if (g.samples_seen != e.samples_seen)
          report_mismatch("count", g.samples_seen, e.samples_seen);
      end
    end
  end

  // Receiver ready: random stall bursts, or a long counted hold-off
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready_i <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        m_axis_tready_i <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(0, 6);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  task automatic test_extremes();
    write_reg(CFG_POINT_COUNT, 16);
    load_table(1'b1);
    // full scale, zero, one code each side
    send_sample(16'h7FFF); send_sample(16'h8000); send_sample(16'h0000);
    send_sample(16'hFFFF); send_sample(16'h0001);
    // load index at top of table and sample again
    send_request(CMD_LOAD, pack_load(15, 20'h7FFFF, 24'h7FFFFF));
    send_sample(16'h5555); send_sample(16'hAAAA);
    drain();
  endtask

  task automatic test_only_negative();
    // max stays at its reset value of zero; done straight after reset
    send_request(CMD_LOAD, pack_load(0, 20'h00000, 24'h000100));
    send_request(CMD_LOAD, pack_load(1, 20'h01000, 24'h000300));
    send_sample(16'hF000); send_sample(16'h8000); send_sample(16'hFFFE);
    drain();
  endtask

  task automatic test_flat_segment();
    write_reg(CFG_POINT_COUNT, 2);
    send_request(CMD_LOAD, pack_load(0, 20'h00400, 24'h001234));
    send_request(CMD_LOAD, pack_load(1, 20'h00400, 24'h00ABCD));
    send_sample(16'h1000); send_sample(16'hC000);
    // point count outside range gets clamped
    drain();
    write_reg(CFG_POINT_COUNT, 0);
    send_sample(16'h0100);
    drain();
    write_reg(CFG_POINT_COUNT, 31);
    send_sample(16'h2000);
    drain();
  endtask

  task automatic test_calibration();
    write_reg(CFG_POINT_COUNT, 16);
    load_table(1'b0);
    write_reg(CFG_CAL_ENABLE, 1);
    write_reg(CFG_CAL_ZERO_IN, 32'h80000);
    write_reg(CFG_CAL_ZERO_OUT, 32'h7FFFF);
    write_reg(CFG_CAL_SLOPE, 32'h7FFFF);
    write_reg(CFG_HOUR_SCALE, 32'hFFFF_FFFF);
    send_sample(16'h7FFF); send_sample(16'h8000);
    drain();
    write_reg(CFG_CAL_SLOPE, 32'h80000);
    write_reg(CFG_CAL_ZERO_OUT, 32'h80000);
    write_reg(CFG_CAL_ZERO_IN, 32'h7FFFF);
    write_reg(CFG_HOUR_SCALE, 0);
    send_sample(16'h7FFF); send_sample(16'h1234);
    drain();
    // index beyond the register list is dropped by the block
    cfg_we_i <= 1'b1; cfg_addr_i <= 3'd7; cfg_wdata_i <= 32'hFFFF_FFFF;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_random(int n_items);
    for (int k = 0; k < n_items; k++) begin
      if (k % 150 == 0) begin
        drain();
        write_reg(CFG_CAL_ENABLE, $urandom_range(0, 1));
        write_reg(CFG_CAL_ZERO_IN, $urandom_range(0, 2000) - 1000);
        write_reg(CFG_CAL_ZERO_OUT, $urandom_range(0, 2000) - 1000);
        write_reg(CFG_CAL_SLOPE, $urandom_range(0, 1) ? 65536 + $urandom_range(0, 8000) - 4000
                                                      : $urandom);
        write_reg(CFG_POINT_COUNT, $urandom_range(2, 16));
        write_reg(CFG_HOUR_SCALE, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4000000));
        load_table(1'b0);
      end
      if ($urandom_range(0, 19) == 0)
        send_request(CMD_LOAD, pack_load(k % 16, 20'(m_tv[k % 16]), 24'($urandom)));
      else
        send_sample(16'($urandom));
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_cycles = 3000;
    for (int k = 0; k < 6; k++) send_sample(16'($urandom));
    drain();
  endtask

  initial begin
    m_cal_en = 0; m_zero_in = 0; m_zero_out = 0; m_slope = 20'sd65536;
    m_npts = 2; m_hour = 32'd1272584;
    m_last = 0; m_min = 32767; m_max = 0; m_sum = 0; m_count = 0;
    foreach (m_tv[i]) begin m_tv[i] = 0; m_tma[i] = 0; end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_only_negative();
    test_extremes();
    test_flat_segment();
    test_calibration();
    test_backpressure();
    test_random(750);
    // final stretch without idling
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random(100);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
